// ===== rtl/pcec_pkg.sv =====
// Package for the pileup context error counter: widths, codes, counter
// locations and the helper functions used by the top level; the site picker uses its types.
// Depends on nothing.
package pcec_pkg;

    localparam int TALLY_W   = 8;
    localparam int CTR_W     = 32;
    localparam int VALUE_W   = 32;
    localparam int NUM_BASES = 4;
    localparam int NUM_SLOTS = 11;
    localparam int NUM_MINOR = 5;
    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 32;

    localparam logic [TALLY_W-1:0] MAX_DEPTH        = 8'd255;
    localparam logic [TALLY_W-1:0] TARGET_DEPTH_RST = 8'd10;
    localparam logic [CTR_W-1:0]   CTR_MAX          = '1;

    localparam logic [2:0] BASE_NONE = 3'd4;

    localparam logic [1:0] CLS_MISMATCH = 2'd0;
    localparam logic [1:0] CLS_CLEAN    = 2'd1;
    localparam logic [1:0] CLS_ONE_ERR  = 2'd2;
    localparam logic [1:0] CLS_OTHER    = 2'd3;

    localparam logic [2:0] REGION_NONE    = 3'd0;
    localparam logic [2:0] REGION_MAJOR   = 3'd1;
    localparam logic [2:0] REGION_MINOR   = 3'd2;
    localparam logic [2:0] REGION_CLEAN   = 3'd3;
    localparam logic [2:0] REGION_ONE_ERR = 3'd4;

    localparam logic [3:0] SLOT_MAJOR    = 4'd0;
    localparam logic [3:0] SLOT_CLEAN0   = 4'd1;
    localparam logic [3:0] SLOT_ONE_ERR0 = 4'd6;

    localparam logic [5:0] IDX_MINOR0   = 6'd4;
    localparam logic [5:0] IDX_CLEAN0   = 6'd9;
    localparam logic [5:0] IDX_ONE_ERR0 = 6'd29;
    localparam logic [5:0] IDX_END      = 6'd49;

    localparam logic REG_TARGET_DEPTH = 1'b0;

    typedef logic [TALLY_W-1:0] tally_t;
    typedef tally_t [NUM_BASES-1:0] tally_arr_t;
    typedef logic [NUM_SLOTS-1:0][CTR_W-1:0] row_t;

    typedef struct packed {
        logic [1:0] cls;
        logic [2:0] maj;
        logic [2:0] min;
        logic [2:0] ctx;
    } pick_t;

    typedef struct packed {
        logic [2:0] region;
        logic [1:0] row;
        logic [3:0] slot;
        logic [2:0] minor_addr;
    } loc_t;

    function automatic tally_t tally_inc(tally_t v);
        return (v == MAX_DEPTH) ? v : v + 1'b1;
    endfunction

    function automatic logic [CTR_W-1:0] sat_inc(logic [CTR_W-1:0] v);
        return (v == CTR_MAX) ? v : v + 1'b1;
    endfunction

    // Each row holds the major counter of one base, then its five clean
    // entries, then its five one-error entries.
    function automatic loc_t decode_index(logic [5:0] idx);
        loc_t       loc;
        logic [4:0] k;
        logic [2:0] rem;
        loc = '0;
        loc.region = REGION_NONE;
        k = '0;
        if (idx < IDX_MINOR0) begin
            loc.region = REGION_MAJOR;
            loc.row = idx[1:0];
            loc.slot = SLOT_MAJOR;
        end else if (idx < IDX_CLEAN0) begin
            loc.region = REGION_MINOR;
            loc.minor_addr = 3'(idx - IDX_MINOR0);
        end else if (idx < IDX_ONE_ERR0) begin
            loc.region = REGION_CLEAN;
            k = 5'(idx - IDX_CLEAN0);
        end else if (idx < IDX_END) begin
            loc.region = REGION_ONE_ERR;
            k = 5'(idx - IDX_ONE_ERR0);
        end
        if (k >= 5'd15) begin
            loc.row = 2'd3;
            rem = 3'(k - 5'd15);
        end else if (k >= 5'd10) begin
            loc.row = (loc.region == REGION_MAJOR) ? loc.row : 2'd2;
            rem = 3'(k - 5'd10);
        end else if (k >= 5'd5) begin
            loc.row = 2'd1;
            rem = 3'(k - 5'd5);
        end else begin
            rem = k[2:0];
        end
        if (loc.region == REGION_CLEAN) begin
            loc.slot = SLOT_CLEAN0 + {1'b0, rem};
        end else if (loc.region == REGION_ONE_ERR) begin
            loc.slot = SLOT_ONE_ERR0 + {1'b0, rem};
        end
        return loc;
    endfunction

endpackage

// ===== rtl/pcec_site_pick.sv =====
// Site picker: chooses the major, minor and preceding base of a finished site
// from its tallies and classifies the site against the target depth.
// Depends on pcec_pkg.
module pcec_site_pick (
    input  pcec_pkg::tally_arr_t base_tally,
    input  pcec_pkg::tally_arr_t ctx_tally,
    input  pcec_pkg::tally_t     site_count,
    input  pcec_pkg::tally_t     target_depth,
    output pcec_pkg::pick_t      pick
);

    pcec_pkg::tally_t n_maj;
    pcec_pkg::tally_t n_min;
    pcec_pkg::tally_t n_ctx;
    logic [2:0]       b_maj;
    logic [2:0]       b_min;
    logic [2:0]       b_ctx;
    logic [1:0]       cls;

    always_comb begin
        n_maj = '0;
        n_min = '0;
        n_ctx = '0;
        b_maj = pcec_pkg::BASE_NONE;
        b_min = pcec_pkg::BASE_NONE;
        b_ctx = pcec_pkg::BASE_NONE;
        for (int b = 0; b < pcec_pkg::NUM_BASES; b++) begin
            if (ctx_tally[b] > n_ctx) begin
                n_ctx = ctx_tally[b];
                b_ctx = 3'(b);
            end
            if (base_tally[b] > n_maj) begin
                n_min = n_maj;
                b_min = b_maj;
                n_maj = base_tally[b];
                b_maj = 3'(b);
            end else if (base_tally[b] > n_min) begin
                n_min = base_tally[b];
                b_min = 3'(b);
            end
        end
        cls = pcec_pkg::CLS_OTHER;
        if (b_maj != pcec_pkg::BASE_NONE) begin
            if (n_maj == target_depth && n_min == '0) begin
                cls = pcec_pkg::CLS_CLEAN;
            end else if (({1'b0, n_maj} + 9'd1) == {1'b0, target_depth} &&
                         n_min == pcec_pkg::tally_t'(1)) begin
                cls = pcec_pkg::CLS_ONE_ERR;
            end
        end
        if (site_count != target_depth) begin
            cls = pcec_pkg::CLS_MISMATCH;
            b_maj = pcec_pkg::BASE_NONE;
            b_min = pcec_pkg::BASE_NONE;
            b_ctx = pcec_pkg::BASE_NONE;
        end
    end

    assign pick = '{cls: cls, maj: b_maj, min: b_min, ctx: b_ctx};

endmodule

// ===== rtl/pileup_context_error_counter_unit.sv =====
// Pileup context error counter: site tallies, counter memories with read-modify-write
// and forwarding, and the output register. Depends on pcec_pkg and pcec_site_pick.
// A command or site-end word passes through stage A, stage B and the output register.
// One word per cycle unless m_ready stalls; each memory is read and written once a cycle.
// Reset sets target_depth to 10, clears the site tallies and the per-entry valid bits,
// so every counter reads as zero at once; no clearing pass is needed.
module pileup_context_error_counter_unit (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_command,
    input  logic [2:0]                    s_base,
    input  logic [2:0]                    s_prev_base,
    input  logic                          s_last_of_site,
    input  logic [5:0]                    s_counter_index,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [1:0]                    m_site_class,
    output logic [2:0]                    m_major_base,
    output logic [2:0]                    m_minor_base,
    output logic [2:0]                    m_context_base,
    output logic [pcec_pkg::VALUE_W-1:0]  m_counter_value,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [pcec_pkg::CFG_AW-1:0]   paddr,
    input  logic [pcec_pkg::CFG_DW-1:0]   pwdata,
    output logic [pcec_pkg::CFG_DW-1:0]   prdata,
    output logic                          pready
);

    pcec_pkg::tally_t     target_depth_reg;
    logic                 cfg_wr;

    pcec_pkg::tally_t     cnt_reg;
    pcec_pkg::tally_arr_t bt_reg;
    pcec_pkg::tally_arr_t ct_reg;
    pcec_pkg::tally_t     cnt_next;
    pcec_pkg::tally_arr_t bt_next;
    pcec_pkg::tally_arr_t ct_next;
    logic                 base_ok;
    logic                 prev_ok;

    logic                 out_free;
    logic                 b_free;
    logic                 a_free;
    logic                 a_adv;
    logic                 b_adv;
    logic                 s_acc;
    logic                 a_load;

    logic                 a_valid_reg;
    logic                 a_cmd_reg;
    pcec_pkg::tally_t     a_cnt_reg;
    pcec_pkg::tally_arr_t a_bt_reg;
    pcec_pkg::tally_arr_t a_ct_reg;
    pcec_pkg::loc_t       a_loc_reg;
    pcec_pkg::pick_t      a_pick;
    logic [1:0]           row_ra;
    logic [2:0]           min_ra;

    logic                 b_valid_reg;
    logic                 b_cmd_reg;
    pcec_pkg::pick_t      b_pick_reg;
    pcec_pkg::loc_t       b_loc_reg;
    logic [1:0]           b_row_addr_reg;
    logic [2:0]           b_min_addr_reg;

    pcec_pkg::row_t       row_mem [pcec_pkg::NUM_BASES];
    logic [pcec_pkg::CTR_W-1:0] min_mem [pcec_pkg::NUM_MINOR];
    logic [pcec_pkg::NUM_BASES-1:0] row_vld_reg;
    logic [pcec_pkg::NUM_MINOR-1:0] min_vld_reg;
    pcec_pkg::row_t       row_rd_reg;
    logic                 row_rd_vld_reg;
    logic [pcec_pkg::CTR_W-1:0] min_rd_reg;
    logic                 min_rd_vld_reg;

    logic                 fwd_row_vld_reg;
    logic [1:0]           fwd_row_addr_reg;
    pcec_pkg::row_t       fwd_row_data_reg;
    logic                 fwd_min_vld_reg;
    logic [2:0]           fwd_min_addr_reg;
    logic [pcec_pkg::CTR_W-1:0] fwd_min_data_reg;

    pcec_pkg::row_t       row_cur;
    pcec_pkg::row_t       row_new;
    logic [pcec_pkg::CTR_W-1:0] min_cur;
    logic [pcec_pkg::CTR_W-1:0] min_new;
    logic [pcec_pkg::CTR_W-1:0] cmd_val;
    logic [3:0]           tbl_slot;
    logic                 b_scored;
    logic                 row_we;
    logic                 min_we;

    logic                 m_valid_reg;
    logic [1:0]           m_site_class_reg;
    logic [2:0]           m_major_base_reg;
    logic [2:0]           m_minor_base_reg;
    logic [2:0]           m_context_base_reg;
    logic [pcec_pkg::VALUE_W-1:0] m_counter_value_reg;

    // Configuration port.
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == pcec_pkg::REG_TARGET_DEPTH) ?
                    pcec_pkg::CFG_DW'(target_depth_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_depth_reg <= pcec_pkg::TARGET_DEPTH_RST;
        end else if (cfg_wr && paddr[2] == pcec_pkg::REG_TARGET_DEPTH) begin
            target_depth_reg <= pwdata[pcec_pkg::TALLY_W-1:0];
        end
    end

    // Pipeline flow.
    assign out_free = !m_valid_reg || m_ready;
    assign b_free   = !b_valid_reg || out_free;
    assign a_adv    = a_valid_reg && b_free;
    assign b_adv    = b_valid_reg && out_free;
    assign a_free   = !a_valid_reg || b_free;
    assign s_ready  = a_free;
    assign s_acc    = s_valid && a_free;
    assign a_load   = s_acc && (s_command || s_last_of_site);

    // Site tallies including the word being accepted.
    assign base_ok = (s_base < 3'd4);
    assign prev_ok = (s_prev_base < 3'd4);

    always_comb begin
        cnt_next = pcec_pkg::tally_inc(cnt_reg);
        for (int b = 0; b < pcec_pkg::NUM_BASES; b++) begin
            bt_next[b] = (base_ok && s_base[1:0] == 2'(b)) ?
                         pcec_pkg::tally_inc(bt_reg[b]) : bt_reg[b];
            ct_next[b] = (base_ok && prev_ok && s_prev_base[1:0] == 2'(b)) ?
                         pcec_pkg::tally_inc(ct_reg[b]) : ct_reg[b];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            bt_reg <= '0;
            ct_reg <= '0;
        end else if (s_acc && !s_command) begin
            if (s_last_of_site) begin
                cnt_reg <= '0;
                bt_reg <= '0;
                ct_reg <= '0;
            end else begin
                cnt_reg <= cnt_next;
                bt_reg <= bt_next;
                ct_reg <= ct_next;
            end
        end
    end

    // Stage A: finished site or counter read command.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_load) begin
            a_valid_reg <= 1'b1;
        end else if (a_adv) begin
            a_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_load) begin
            a_cmd_reg <= s_command;
            a_cnt_reg <= cnt_next;
            a_bt_reg <= bt_next;
            a_ct_reg <= ct_next;
            a_loc_reg <= pcec_pkg::decode_index(s_counter_index);
        end
    end

    pcec_site_pick u_pick (
        .base_tally   (a_bt_reg),
        .ctx_tally    (a_ct_reg),
        .site_count   (a_cnt_reg),
        .target_depth (target_depth_reg),
        .pick         (a_pick)
    );

    assign row_ra = a_cmd_reg ? a_loc_reg.row : a_pick.maj[1:0];
    assign min_ra = a_cmd_reg ? a_loc_reg.minor_addr : a_pick.min;

    // Counter memories: read as stage A moves on, written back from stage B.
    always_ff @(posedge aclk) begin
        if (a_adv) begin
            row_rd_reg <= row_mem[row_ra];
            row_rd_vld_reg <= row_vld_reg[row_ra];
            min_rd_reg <= min_mem[min_ra];
            min_rd_vld_reg <= min_vld_reg[min_ra];
        end
        if (row_we) begin
            row_mem[b_row_addr_reg] <= row_new;
        end
        if (min_we) begin
            min_mem[b_min_addr_reg] <= min_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_vld_reg <= '0;
            min_vld_reg <= '0;
            fwd_row_vld_reg <= 1'b0;
            fwd_min_vld_reg <= 1'b0;
        end else begin
            if (row_we) begin
                row_vld_reg[b_row_addr_reg] <= 1'b1;
                fwd_row_vld_reg <= 1'b1;
            end
            if (min_we) begin
                min_vld_reg[b_min_addr_reg] <= 1'b1;
                fwd_min_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (row_we) begin
            fwd_row_addr_reg <= b_row_addr_reg;
            fwd_row_data_reg <= row_new;
        end
        if (min_we) begin
            fwd_min_addr_reg <= b_min_addr_reg;
            fwd_min_data_reg <= min_new;
        end
    end

    // Stage B: counter update and result assembly.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (a_adv) begin
            b_valid_reg <= 1'b1;
        end else if (b_adv) begin
            b_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_adv) begin
            b_cmd_reg <= a_cmd_reg;
            b_pick_reg <= a_pick;
            b_loc_reg <= a_loc_reg;
            b_row_addr_reg <= row_ra;
            b_min_addr_reg <= min_ra;
        end
    end

    // The newest write to an entry wins over the memory's read data.
    always_comb begin
        if (fwd_row_vld_reg && fwd_row_addr_reg == b_row_addr_reg) begin
            row_cur = fwd_row_data_reg;
        end else begin
            row_cur = row_rd_vld_reg ? row_rd_reg : '0;
        end
        if (fwd_min_vld_reg && fwd_min_addr_reg == b_min_addr_reg) begin
            min_cur = fwd_min_data_reg;
        end else begin
            min_cur = min_rd_vld_reg ? min_rd_reg : '0;
        end
    end

    assign tbl_slot = ((b_pick_reg.cls == pcec_pkg::CLS_CLEAN) ?
                       pcec_pkg::SLOT_CLEAN0 : pcec_pkg::SLOT_ONE_ERR0) +
                      {1'b0, b_pick_reg.ctx};

    always_comb begin
        row_new = row_cur;
        row_new[pcec_pkg::SLOT_MAJOR] = pcec_pkg::sat_inc(row_cur[pcec_pkg::SLOT_MAJOR]);
        if (b_pick_reg.cls == pcec_pkg::CLS_CLEAN || b_pick_reg.cls == pcec_pkg::CLS_ONE_ERR) begin
            row_new[tbl_slot] = pcec_pkg::sat_inc(row_cur[tbl_slot]);
        end
    end

    assign min_new  = pcec_pkg::sat_inc(min_cur);
    assign b_scored = !b_cmd_reg && (b_pick_reg.cls != pcec_pkg::CLS_MISMATCH);
    assign row_we   = b_adv && b_scored && (b_pick_reg.maj != pcec_pkg::BASE_NONE);
    assign min_we   = b_adv && b_scored;

    always_comb begin
        unique case (b_loc_reg.region)
            pcec_pkg::REGION_MINOR: begin
                cmd_val = min_cur;
            end
            pcec_pkg::REGION_MAJOR, pcec_pkg::REGION_CLEAN, pcec_pkg::REGION_ONE_ERR: begin
                cmd_val = row_cur[b_loc_reg.slot];
            end
            default: begin
                cmd_val = '0;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (b_adv) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_adv) begin
            if (b_cmd_reg) begin
                m_site_class_reg <= pcec_pkg::CLS_MISMATCH;
                m_major_base_reg <= pcec_pkg::BASE_NONE;
                m_minor_base_reg <= pcec_pkg::BASE_NONE;
                m_context_base_reg <= pcec_pkg::BASE_NONE;
                m_counter_value_reg <= cmd_val[pcec_pkg::VALUE_W-1:0];
            end else begin
                m_site_class_reg <= b_pick_reg.cls;
                m_major_base_reg <= b_pick_reg.maj;
                m_minor_base_reg <= b_pick_reg.min;
                m_context_base_reg <= b_pick_reg.ctx;
                m_counter_value_reg <= '0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_site_class    = m_site_class_reg;
    assign m_major_base    = m_major_base_reg;
    assign m_minor_base    = m_minor_base_reg;
    assign m_context_base  = m_context_base_reg;
    assign m_counter_value = m_counter_value_reg;

`ifndef SYNTHESIS
    a_load_enters_stage: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && (s_command || s_last_of_site)) |=> a_valid_reg)
        else $error("accepted command or site end did not enter stage A");

    a_scored_has_major: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && (m_site_class_reg == pcec_pkg::CLS_CLEAN ||
                         m_site_class_reg == pcec_pkg::CLS_ONE_ERR))
        |-> (m_major_base_reg != pcec_pkg::BASE_NONE))
        else $error("clean or one-error site without a major base");

    a_site_value_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_site_class_reg != pcec_pkg::CLS_MISMATCH)
        |-> (m_counter_value_reg == '0))
        else $error("scored site word carries a counter value");

    a_row_write_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        row_we |=> row_vld_reg[$past(b_row_addr_reg)])
        else $error("written counter row not marked valid");
`endif

endmodule
